### src/palindrome_word_counter_defines.svh
// Assertion helpers for the palindrome word counter checks.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef PALINDROME_WORD_COUNTER_DEFINES_SVH
`define PALINDROME_WORD_COUNTER_DEFINES_SVH

// Same-cycle implication.
`define PWC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwc check failed");

// Next-cycle implication.
`define PWC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwc check failed");

`endif

### src/pwc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pwc_pkg;

    localparam int MAX_WORD   = 64;
    localparam int COUNT_BITS = 32;

    localparam int LEN_W  = $clog2(MAX_WORD + 1);
    localparam int HALF_W = $clog2(MAX_WORD / 2 + 1);

    // fixed field widths
    localparam int WLEN_W  = 7;
    localparam int CNT_W   = 32;
    localparam int MINL_W  = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_CHECK_ON = CFG_IDX_W'(1);

    localparam logic [7:0] UPPER_A     = 8'd65;
    localparam logic [7:0] UPPER_Z     = 8'd90;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam logic [MINL_W-1:0] MIN_LENGTH_RST = MINL_W'(2);

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } pwc_in_t;

    typedef struct packed {
        logic [WLEN_W-1:0] word_length;
        logic              is_palindrome;
        logic              word_counted;
        logic              word_too_long;
        logic [CNT_W-1:0]  palindrome_count;
        logic              final_result;
    } pwc_out_t;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic       load;      // byte enters: forward chain shifts right
        logic       shift;     // check step: both chains shift left
        logic [7:0] data;      // folded byte
    } pwc_cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_CHECK  = 3'b010,
        ST_FINISH = 3'b100
    } pwc_state_t;

    function automatic logic is_delim(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h3A) || (b == 8'h2C) || (b == 8'h3B) ||
               (b == 8'h2E) || (b == 8'h2D) || (b == 8'h0A) || (b == 8'h09) ||
               (b == 8'h0D) || (b == 8'h23) || (b == 8'h00);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        return ((b >= UPPER_A) && (b <= UPPER_Z)) ? b + CASE_OFFSET : b;
    endfunction

endpackage

`default_nettype wire

### src/palindrome_word_counter.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake          | Payload
// in       | to block  | in_valid/in_stall  | in_data   (pwc_in_t)
// out      | from block| out_valid/out_stall| out_data  (pwc_out_t)
// cfg      | to block  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A byte that does not close a word is taken while in_stall stays low.
// A closing byte raises in_stall through the compare walk and the finishing state
//   (an overflowed word skips the walk): the compare walk moves both cell chains one position per cycle.
// While the result register holds an untaken result, the finishing cycle waits and
//   in_stall stays high; no byte is taken until that result has made its transfer.
// rst_n is asynchronous, active low; configuration resets to min_length 2, check on.
module palindrome_word_counter
    import pwc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire pwc_in_t              in_data,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output pwc_out_t                  out_data,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MINL_W-1:0] min_length_reg, min_length_next;
    logic              len_check_reg, len_check_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        min_length_next = min_length_reg;
        len_check_next  = len_check_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MIN_LENGTH:      min_length_next = MINL_W'(cfg_data);
                REG_LENGTH_CHECK_ON: len_check_next  = cfg_data[0];
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Word state and sequencer
    // ------------------------------------------------------------------
    pwc_state_t          state_reg, state_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                ovf_reg, ovf_next;
    logic                pal_reg, pal_next;
    logic                final_reg, final_next;
    logic [HALF_W-1:0]   half_reg, half_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    pwc_out_t            out_reg, out_next;

    logic              in_xfer;
    logic              byte_delim;
    logic [7:0]        byte_folded;
    logic              word_full;
    logic              load_en;
    logic              close_word;
    logic [LEN_W-1:0]  len_new;
    logic              ovf_new;
    logic [HALF_W-1:0] half_new;
    logic              out_free;
    logic              counted;

    // chain taps
    logic [7:0] fwd_q    [MAX_WORD];
    logic [7:0] rev_q    [MAX_WORD];
    logic [7:0] fwd_left [MAX_WORD];
    logic [7:0] fwd_right[MAX_WORD];
    logic [7:0] rev_right[MAX_WORD];
    logic [MAX_WORD-1:0] wr_sel;
    pwc_cell_ctl_t cell_ctl;

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_xfer     = in_valid && !in_stall;
    assign byte_delim  = is_delim(in_data.text_byte);
    assign byte_folded = fold_case(in_data.text_byte);
    assign word_full   = (len_reg == LEN_W'(MAX_WORD));
    assign load_en     = in_xfer && !byte_delim && !word_full;
    assign close_word  = in_data.end_of_text || (byte_delim && (len_reg != '0));
    assign len_new     = load_en ? len_reg + LEN_W'(1) : len_reg;
    assign ovf_new     = ovf_reg || (!byte_delim && word_full);
    assign half_new    = HALF_W'(len_new >> 1);

    // output register frees up when its transfer completes this cycle
    assign out_free    = !out_valid_reg || !out_stall;

    // length test: min_length is compared as its full value
    assign counted = pal_reg &&
                     (!len_check_reg || (32'(len_reg) > 32'(min_length_reg)));

    assign cell_ctl.load  = load_en;
    assign cell_ctl.shift = (state_reg == ST_CHECK);
    assign cell_ctl.data  = byte_folded;

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        pal_next       = pal_reg;
        final_next     = final_reg;
        half_next      = half_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    len_next = len_new;
                    ovf_next = ovf_new;
                    if (close_word)
                    begin
                        // a lone letter is trivially a palindrome; the walk may clear it
                        pal_next   = (len_new != '0) && !ovf_new;
                        final_next = in_data.end_of_text;
                        half_next  = half_new;
                        if (!ovf_new && (half_new != '0))
                        begin
                            state_next = ST_CHECK;
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                end
            end
            ST_CHECK:
            begin
                // chain heads: forward holds word[L-1-k], in-order holds word[k]
                if (fwd_q[0] != rev_q[0])
                begin
                    pal_next = 1'b0;
                end
                half_next = half_reg - HALF_W'(1);
                if (half_reg == HALF_W'(1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    if (counted && (count_reg != '1))
                    begin
                        count_next = count_reg + COUNT_BITS'(1);
                    end
                    out_next.word_length      = WLEN_W'(len_reg);
                    out_next.is_palindrome    = pal_reg;
                    out_next.word_counted     = counted;
                    out_next.word_too_long    = ovf_reg;
                    out_next.palindrome_count = CNT_W'(
                        (counted && (count_reg != '1)) ? count_reg + COUNT_BITS'(1)
                                                       : count_reg);
                    out_next.final_result     = final_reg;
                    out_valid_next            = 1'b1;
                    len_next                  = '0;
                    ovf_next                  = 1'b0;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            len_reg        <= '0;
            ovf_reg        <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            min_length_reg <= MIN_LENGTH_RST;
            len_check_reg  <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            ovf_reg        <= ovf_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            min_length_reg <= min_length_next;
            len_check_reg  <= len_check_next;
        end
    end

    // payload-only registers
    always_ff @(posedge clk)
    begin
        pal_reg   <= pal_next;
        final_reg <= final_next;
        half_reg  <= half_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ------------------------------------------------------------------
    // Cell chain: new bytes shift in at cell 0 of the forward copy and are
    // written in place in the in-order copy; the check shifts both left.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < MAX_WORD; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign fwd_left[i] = byte_folded;
        end
        else
        begin : g_mid
            assign fwd_left[i] = fwd_q[i-1];
        end

        if (i == MAX_WORD - 1)
        begin : g_tail
            assign fwd_right[i] = 8'h00;
            assign rev_right[i] = 8'h00;
        end
        else
        begin : g_body
            assign fwd_right[i] = fwd_q[i+1];
            assign rev_right[i] = rev_q[i+1];
        end

        assign wr_sel[i] = (len_reg == LEN_W'(i));

        pwc_cell u_cell (
            .clk       (clk),
            .ctl       (cell_ctl),
            .wr_sel    (wr_sel[i]),
            .fwd_left  (fwd_left[i]),
            .fwd_right (fwd_right[i]),
            .rev_right (rev_right[i]),
            .fwd_q     (fwd_q[i]),
            .rev_q     (rev_q[i])
        );
    end

endmodule

`default_nettype wire

### src/pwc_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One byte position of the word: a forward copy (newest byte at the head)
// and an in-order copy (written at its own position).
module pwc_cell
    import pwc_pkg::*;
(
    input  wire logic          clk,
    input  wire pwc_cell_ctl_t ctl,
    input  wire logic          wr_sel,
    input  wire logic [7:0]    fwd_left,
    input  wire logic [7:0]    fwd_right,
    input  wire logic [7:0]    rev_right,
    output logic [7:0]         fwd_q,
    output logic [7:0]         rev_q
);

    logic [7:0] fwd_reg, fwd_next;
    logic [7:0] rev_reg, rev_next;

    always_comb
    begin
        fwd_next = fwd_reg;
        rev_next = rev_reg;
        if (ctl.load)
        begin
            fwd_next = fwd_left;
            if (wr_sel)
            begin
                rev_next = ctl.data;
            end
        end
        else if (ctl.shift)
        begin
            fwd_next = fwd_right;
            rev_next = rev_right;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_reg <= fwd_next;
        rev_reg <= rev_next;
    end

    assign fwd_q = fwd_reg;
    assign rev_q = rev_reg;

endmodule

`default_nettype wire

### src/pwc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "palindrome_word_counter_defines.svh"

module pwc_checker
    import pwc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire pwc_out_t             out_data
);

    // a held result keeps its contents
    `PWC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // counted words are judged palindromes that fit the buffer
    `PWC_ASSERT_NOW(a_counted_ok, out_valid && out_data.word_counted,
        out_data.is_palindrome && !out_data.word_too_long && (out_data.palindrome_count != '0))

    // an overflowed word reports the full buffer length and no verdict
    `PWC_ASSERT_NOW(a_overflow, out_valid && out_data.word_too_long,
        (out_data.word_length == WLEN_W'(MAX_WORD)) && !out_data.is_palindrome)

    // an empty close only happens on the final result
    `PWC_ASSERT_NOW(a_empty_final, out_valid && (out_data.word_length == '0),
        out_data.final_result && !out_data.is_palindrome)

endmodule

bind palindrome_word_counter pwc_checker u_pwc_checker (.*);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

// Checks the palindrome word counter against its own model of the tokenizer
// and the mirror check. A short scripted text runs first under the reset
// configuration. Random words then run in phases, and each phase changes
// min_length and length_check_on while the block is idle.
module tb;
    import pwc_pkg::*;

    // Word breaks: space : , ; . - LF TAB CR # NUL
    localparam logic [10:0][7:0] BREAK_CHARS = {
        8'h20, 8'h3A, 8'h2C, 8'h3B, 8'h2E, 8'h2D, 8'h0A, 8'h09, 8'h0D, 8'h23, 8'h00
    };
    localparam int NUM_ROWS    = 26;
    localparam int RANDOM_BYTES = 800;
    // A closing byte holds the block through its compare walk; give it room to drain.
    localparam int DRAIN_CYCLES = 40;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    pwc_in_t              in_data;
    logic                 out_valid;
    logic                 out_stall;
    pwc_out_t             out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    palindrome_word_counter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Model state: open word, overflow, running total and both registers.
    logic [7:0]       word_buf [MAX_WORD];
    int unsigned      open_len;
    bit               spilled;
    logic [CNT_W-1:0] counted;
    logic [MINL_W-1:0] min_len;
    bit               check_on;

    pwc_out_t expected_words [$];
    int       bad_fields;
    int       bytes_sent;
    bit       quiet;        // no idling on either side while set

    // One scripted byte; where known is set the result is typed in by hand.
    typedef struct {
        logic [7:0] text;
        bit         eot;
        bit         known;
        pwc_out_t   want;
    } script_row_t;

    script_row_t script [NUM_ROWS];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic bit is_break(input logic [7:0] b);
        for (int i = 0; i < 11; i++)
        begin
            if (BREAK_CHARS[i] == b)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Feeds one byte to the model; returns whether it closes a word and the verdict.
    function automatic void judge_text_byte(input pwc_in_t item, output bit closes,
                                            output pwc_out_t verdict);
        logic [7:0]  c;
        bit          brk;
        int unsigned n;
        bit          pal;
        bit          cnt;
        c       = item.text_byte;
        brk     = is_break(c);
        closes  = 1'b0;
        verdict = '0;
        if (!brk)
        begin
            if (c >= UPPER_A && c <= UPPER_Z)
                c = c + CASE_OFFSET;
            if (open_len < MAX_WORD)
            begin
                word_buf[open_len] = c;
                open_len++;
            end
            else
                spilled = 1'b1;
        end
        if (item.end_of_text || (brk && open_len > 0))
        begin
            closes = 1'b1;
            n      = open_len;
            pal    = 1'b0;
            cnt    = 1'b0;
            if (n > 0 && !spilled)
            begin
                pal = 1'b1;
                for (int i = 0; i < n / 2; i++)
                begin
                    if (word_buf[i] != word_buf[n - 1 - i])
                        pal = 1'b0;
                end
                cnt = pal && (!check_on || n > min_len);
                if (cnt && !(&counted))
                    counted = counted + 1'b1;
            end
            verdict.word_length      = WLEN_W'(n);
            verdict.is_palindrome    = pal;
            verdict.word_counted     = cnt;
            verdict.word_too_long    = spilled;
            verdict.palindrome_count = counted;
            verdict.final_result     = item.end_of_text;
            open_len = 0;
            spilled  = 1'b0;
        end
    endfunction

    // Offers one byte, waits for its transfer, then records what it should cause.
    task automatic push_byte(input logic [7:0] b, input bit eot, input bit known,
                             input pwc_out_t want);
        pwc_in_t  item;
        pwc_out_t verdict;
        bit       closes;
        item.text_byte   = b;
        item.end_of_text = eot;
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        judge_text_byte(item, closes, verdict);
        if (closes)
            expected_words.push_back(known ? want : verdict);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_MIN_LENGTH)
            min_len = val;
        else if (idx == REG_LENGTH_CHECK_ON)
            check_on = val[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits for every pending word, then lets the block finish any internal work.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_char();
        int         r;
        logic [7:0] c;
        r = $urandom_range(99);
        if (r < 70)
            return 8'($urandom_range(8'h61, 8'h7A));
        if (r < 85)
            return 8'($urandom_range(UPPER_A, UPPER_Z));
        c = 8'($urandom);
        while (is_break(c))
            c = 8'($urandom);
        return c;
    endfunction

    // Flips the case of a letter half the time; other bytes pass through.
    function automatic logic [7:0] recase(input logic [7:0] c);
        if ($urandom_range(1) == 0)
            return c;
        if (c >= UPPER_A && c <= UPPER_Z)
            return c + CASE_OFFSET;
        if (c >= 8'h61 && c <= 8'h7A)
            return c - CASE_OFFSET;
        return c;
    endfunction

    // A whole word with its closing: mostly short, a few up to and past the buffer.
    task automatic emit_word();
        int         r;
        int         len;
        int         ending;
        logic [7:0] w [$];
        r = $urandom_range(99);
        if (r < 75)
            len = $urandom_range(1, 8);
        else if (r < 90)
            len = $urandom_range(9, 20);
        else if (r < 96)
            len = $urandom_range(21, MAX_WORD);
        else
            len = $urandom_range(MAX_WORD + 1, MAX_WORD + 6);
        for (int i = 0; i < len; i++)
            w.push_back(pick_char());
        if ($urandom_range(99) < 60)
        begin
            for (int i = 0; i < len / 2; i++)
                w[len - 1 - i] = recase(w[i]);
        end
        r = $urandom_range(99);
        ending = (r < 65) ? 0 : (r < 82) ? 1 : 2;
        for (int i = 0; i < len; i++)
            push_byte(w[i], ending == 1 && i == len - 1, 1'b0, '0);
        if (ending == 0)
        begin
            repeat ($urandom_range(1, 3))
                push_byte(BREAK_CHARS[$urandom_range(10)], 1'b0, 1'b0, '0);
        end
        else if (ending == 2)
            push_byte(BREAK_CHARS[$urandom_range(10)], 1'b1, 1'b0, '0);
    endtask

    task automatic check_word(input pwc_out_t got);
        pwc_out_t want;
        if (expected_words.size() == 0)
        begin
            $error("unexpected result: word_length %0d, palindrome_count %0d",
                   got.word_length, got.palindrome_count);
            bad_fields++;
        end
        else
        begin
            want = expected_words.pop_front();
            if (got.word_length !== want.word_length)
            begin
                $error("word_length: expected %0d, got %0d", want.word_length,
                       got.word_length);
                bad_fields++;
            end
            if (got.is_palindrome !== want.is_palindrome)
            begin
                $error("is_palindrome: expected %0d, got %0d", want.is_palindrome,
                       got.is_palindrome);
                bad_fields++;
            end
            if (got.word_counted !== want.word_counted)
            begin
                $error("word_counted: expected %0d, got %0d", want.word_counted,
                       got.word_counted);
                bad_fields++;
            end
            if (got.word_too_long !== want.word_too_long)
            begin
                $error("word_too_long: expected %0d, got %0d", want.word_too_long,
                       got.word_too_long);
                bad_fields++;
            end
            if (got.palindrome_count !== want.palindrome_count)
            begin
                $error("palindrome_count: expected %0d, got %0d", want.palindrome_count,
                       got.palindrome_count);
                bad_fields++;
            end
            if (got.final_result !== want.final_result)
            begin
                $error("final_result: expected %0d, got %0d", want.final_result,
                       got.final_result);
                bad_fields++;
            end
        end
    endtask

    // Result transfers are taken at the rising edge, before any flop updates.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_word(out_data);
    end

    // Receiver back-pressure, changed on the falling edge.
    initial
    begin
        forever
        begin
            @(negedge clk);
            out_stall <= !quiet && ($urandom_range(99) < 35);
        end
    end

    initial
    begin
        int                   phase;
        int                   stop_at;
        logic [MINL_W-1:0]    lim;
        bit                   on;
        logic [CFG_DAT_W-1:0] on_word;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        quiet     = 1'b0;
        bad_fields = 0;
        bytes_sent = 0;
        open_len  = 0;
        spilled   = 1'b0;
        counted   = '0;
        min_len   = MIN_LENGTH_RST;
        check_on  = 1'b1;

        // Scripted text under the reset configuration (min_length 2, check on).
        script = '{
            // end of text with nothing open still reports
            '{8'h00, 1'b1, 1'b1, pwc_out_t'{7'd0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b1}},
            '{8'h20, 1'b0, 1'b0, '0},               // break, no word open
            '{8'h41, 1'b0, 1'b0, '0},               // "Aba": folds to a palindrome
            '{8'h62, 1'b0, 1'b0, '0},
            '{8'h61, 1'b0, 1'b0, '0},
            '{8'h2C, 1'b0, 1'b1, pwc_out_t'{7'd3, 1'b1, 1'b1, 1'b0, 32'd1, 1'b0}},
            '{8'h5A, 1'b0, 1'b0, '0},               // "Zz": length 2 is not over 2
            '{8'h7A, 1'b0, 1'b0, '0},
            '{8'h3A, 1'b0, 1'b1, pwc_out_t'{7'd2, 1'b1, 1'b0, 1'b0, 32'd1, 1'b0}},
            // letter with end of text joins first, then closes
            '{8'h78, 1'b1, 1'b1, pwc_out_t'{7'd1, 1'b1, 1'b0, 1'b0, 32'd1, 1'b1}},
            '{8'h40, 1'b0, 1'b0, '0},               // just below A / just above Z
            '{8'h60, 1'b0, 1'b0, '0},
            '{8'h2E, 1'b0, 1'b0, '0},
            '{8'h5B, 1'b0, 1'b0, '0},
            '{8'h7B, 1'b0, 1'b0, '0},
            '{8'h2D, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},               // top byte as a one-letter word
            '{8'h0A, 1'b0, 1'b1, pwc_out_t'{7'd1, 1'b1, 1'b0, 1'b0, 32'd1, 1'b0}},
            '{8'h71, 1'b0, 1'b0, '0},
            '{8'h51, 1'b0, 1'b0, '0},
            '{8'h71, 1'b0, 1'b0, '0},
            '{8'h3B, 1'b0, 1'b1, pwc_out_t'{7'd3, 1'b1, 1'b1, 1'b0, 32'd2, 1'b0}},
            '{8'h23, 1'b0, 1'b0, '0},
            '{8'h0D, 1'b0, 1'b0, '0},
            '{8'h09, 1'b0, 1'b0, '0},
            '{8'h7F, 1'b1, 1'b1, pwc_out_t'{7'd1, 1'b1, 1'b0, 1'b0, 32'd2, 1'b1}}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
            push_byte(script[i].text, script[i].eot, script[i].known, script[i].want);

        // Random phases, each under its own register setting.
        phase = 0;
        while (bytes_sent < NUM_ROWS + RANDOM_BYTES)
        begin
            drain();
            case (phase)
                0: begin lim = 7'd0;   on = 1'b1; end
                1: begin lim = 7'd1;   on = 1'b0; end
                2: begin lim = 7'd64;  on = 1'b1; end
                3: begin lim = 7'd127; on = 1'b1; end
                4: begin lim = 7'd63;  on = 1'b1; end
                5: begin lim = 7'd127; on = 1'b0; end
                default:
                begin
                    lim = 7'($urandom_range(0, 127));
                    on  = $urandom_range(1);
                end
            endcase
            // Upper bits of the check register are don't-care; toggle them anyway.
            on_word = {6'($urandom), on};
            if ($urandom_range(1))
            begin
                write_reg(REG_MIN_LENGTH, lim);
                write_reg(REG_LENGTH_CHECK_ON, on_word);
            end
            else
            begin
                write_reg(REG_LENGTH_CHECK_ON, on_word);
                write_reg(REG_MIN_LENGTH, lim);
            end
            quiet   = (phase == 2);
            stop_at = bytes_sent + 100;
            while (bytes_sent < stop_at)
            begin
                if ($urandom_range(99) < 85)
                    emit_word();
                else
                    push_byte(8'($urandom), $urandom_range(19) == 0, 1'b0, '0);
            end
            // Close the phase so no word straddles a register change.
            push_byte(pick_char(), 1'b1, 1'b0, '0);
            quiet = 1'b0;
            phase++;
        end

        drain();
        if (bad_fields == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
